// ===== rtl/dsw_pkg.sv =====
// ----------------------------------------------------------------------------
// Dice sum ways counter package
// Shared widths, limits, the modulus, the stream word between cells and
// the controller state type.
// ----------------------------------------------------------------------------
package dsw_pkg;

  localparam int MAX_DICE   = 32;
  localparam int MAX_FACES  = 32;
  localparam int MAX_TARGET = 1023;

  localparam int DICE_W   = 6;
  localparam int FACES_W  = 6;
  localparam int TARGET_W = 10;
  localparam int WAYS_W   = 30;
  localparam int TAP_W    = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

  localparam logic [WAYS_W-1:0] WAYS_MOD = WAYS_W'(1000000007);

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [WAYS_W-1:0] value;
  } dsw_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_DONE
  } dsw_state_t;

endpackage

// ===== rtl/dsw_ifs.sv =====
// ----------------------------------------------------------------------------
// Dice sum ways counter channels
// Valid/ready channels for the query word and the result word.
// ----------------------------------------------------------------------------
interface dsw_req_if
  import dsw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DICE_W-1:0]   dice;
  logic [FACES_W-1:0]  faces;
  logic [TARGET_W-1:0] target_sum;

  modport source (output valid, dice, faces, target_sum, input ready);
  modport sink (input valid, dice, faces, target_sum, output ready);
endinterface

interface dsw_rsp_if
  import dsw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WAYS_W-1:0] ways;

  modport source (output valid, ways, input ready);
  modport sink (input valid, ways, output ready);
endinterface

// ===== rtl/dsw_cell.sv =====
// ----------------------------------------------------------------------------
// Dice sum ways cell
// One die of the chain: turns the stream of counts for the previous dice
// into the stream for one more die with a sliding window sum modulo the prime.
// ----------------------------------------------------------------------------
module dsw_cell
  import dsw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               active,
  input  logic [FACES_W-1:0] faces,
  input  dsw_word_t          din,
  output dsw_word_t          dout
);

  logic [WAYS_W-1:0] win;
  logic [WAYS_W-1:0] win_next;
  logic [WAYS_W-1:0] taps [MAX_FACES];
  logic [WAYS_W-1:0] win_cur;
  logic [WAYS_W-1:0] tap_old;
  logic [WAYS_W-1:0] diff_mod;
  logic [WAYS_W:0]   diff;
  logic [WAYS_W:0]   sum;
  logic [FACES_W-1:0] faces_m1;
  logic [TAP_W-1:0]  tap_idx;
  logic [WAYS_W-1:0] value_out;

  always_comb begin
    faces_m1 = faces - FACES_W'(1);
    tap_idx  = faces_m1[TAP_W-1:0];
    win_cur  = din.first ? '0 : win;
    tap_old  = din.first ? '0 : taps[tap_idx];
    diff     = {1'b0, win_cur} - {1'b0, tap_old};
    diff_mod = diff[WAYS_W] ? WAYS_W'(diff + {1'b0, WAYS_MOD}) : diff[WAYS_W-1:0];
    sum      = {1'b0, diff_mod} + {1'b0, din.value};
    win_next = (sum >= {1'b0, WAYS_MOD}) ? WAYS_W'(sum - {1'b0, WAYS_MOD})
                                         : sum[WAYS_W-1:0];
    if (!active) begin
      value_out = din.value;
    end else if (faces == '0) begin
      value_out = '0;
    end else begin
      value_out = win_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.first <= din.first;
    dout.last  <= din.last;
    dout.value <= value_out;
    if (din.valid) begin
      win     <= win_next;
      taps[0] <= din.value;
      for (int i = 1; i < MAX_FACES; i++) begin
        taps[i] <= din.first ? '0 : taps[i-1];
      end
    end
  end

endmodule

// ===== rtl/dice_sum_ways_counter.sv =====
// ----------------------------------------------------------------------------
// Dice sum ways counter
// Counts the ordered rolls of up to 32 dice that reach a target sum,
// modulo 1000000007, by streaming a row of counts through a chain of cells.
//
//   Channel   Role   Word fields
//   req       sink   dice, faces, target_sum
//   rsp       source ways
//
// A query streams target_sum + 1 counts into a chain of MAX_DICE cells, one
// per die; cells past the dice count pass the stream through. The result word
// is taken from the last cell into a hold register and then loaded into the
// output register. One query is in work at a time.
// Reset clears the controller and the chain valid flags. A stalled result
// word holds in the output register while the next query is accepted.
// ----------------------------------------------------------------------------
module dice_sum_ways_counter
  import dsw_pkg::*;
(
  input logic     clk,
  input logic     rst,
  dsw_req_if.sink   req,
  dsw_rsp_if.source rsp
);

  dsw_state_t          state;
  dsw_state_t          state_next;
  logic [TARGET_W-1:0] k;
  logic [DICE_W-1:0]   dice_reg;
  logic [FACES_W-1:0]  faces_reg;
  logic [TARGET_W-1:0] target_reg;
  logic [WAYS_W-1:0]   ways_hold;
  logic                rsp_valid;
  logic [WAYS_W-1:0]   rsp_ways;
  logic                load_out;
  logic                accept;
  dsw_word_t           link [MAX_DICE+1];

  assign rsp.valid = rsp_valid;
  assign rsp.ways  = rsp_ways;
  assign accept    = req.valid && req.ready;

  always_comb begin
    link[0].valid = (state == ST_FEED);
    link[0].first = (k == '0);
    link[0].last  = (k == target_reg);
    link[0].value = (k == '0) ? WAYS_W'(1) : '0;
  end

  for (genvar j = 0; j < MAX_DICE; j++) begin : g_cell
    dsw_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .active (dice_reg > DICE_W'(j)),
      .faces  (faces_reg),
      .din    (link[j]),
      .dout   (link[j+1])
    );
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_FEED;
        end
      end
      ST_FEED: begin
        if (k == target_reg) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (link[MAX_DICE].valid && link[MAX_DICE].last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dice_reg   <= (req.dice > DICE_W'(MAX_DICE)) ? DICE_W'(MAX_DICE) : req.dice;
      faces_reg  <= (req.faces > FACES_W'(MAX_FACES)) ? FACES_W'(MAX_FACES) : req.faces;
      target_reg <= req.target_sum;
      k          <= '0;
    end else if (state == ST_FEED) begin
      k <= k + TARGET_W'(1);
    end
    if (state == ST_DRAIN && link[MAX_DICE].valid && link[MAX_DICE].last) begin
      ways_hold <= link[MAX_DICE].value;
    end
    if (load_out) begin
      rsp_ways <= ways_hold;
    end
  end

endmodule

// ===== test/dice_sum_ways_check.sv =====
// ----------------------------------------------------------------------------
// Dice sum ways result checker
// Watches the query and result channels of the dice sum ways counter. For
// each accepted query it counts the ordered rolls that reach the target with
// a row-by-row window sum, queues the count, and compares every result word
// with the oldest queued count. It hands the failure count and the number of
// outstanding results to the testbench top.
// ----------------------------------------------------------------------------
module dice_sum_ways_check
  import dsw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dsw_req_if   req_mon,
  dsw_rsp_if   rsp_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic [DICE_W-1:0]   dice;
    logic [FACES_W-1:0]  faces;
    logic [TARGET_W-1:0] target_sum;
    logic [WAYS_W-1:0]   ways;
  } roll_query_t;

  roll_query_t ways_expected[$];

  function automatic logic [WAYS_W-1:0] count_rolls(
    input logic [DICE_W-1:0]   dice_in,
    input logic [FACES_W-1:0]  faces_in,
    input logic [TARGET_W-1:0] target_in
  );
    int unsigned     n_dice;
    int unsigned     n_faces;
    int unsigned     tgt;
    int unsigned     cur;
    int unsigned     nxt;
    longint unsigned modulus;
    longint unsigned win;
    longint unsigned row [2][0:MAX_TARGET];
    n_dice  = (dice_in > MAX_DICE) ? MAX_DICE : dice_in;
    n_faces = (faces_in > MAX_FACES) ? MAX_FACES : faces_in;
    tgt     = target_in;
    modulus = longint'(WAYS_MOD);
    for (int k = 0; k <= MAX_TARGET; k++) begin
      row[0][k] = 0;
      row[1][k] = 0;
    end
    row[0][0] = 1;
    cur = 0;
    for (int unsigned d = 0; d < n_dice; d++) begin
      nxt = cur ^ 1;
      for (int k = 0; k <= MAX_TARGET; k++) begin
        row[nxt][k] = 0;
      end
      win = 0;
      for (int unsigned k = 1; k <= tgt; k++) begin
        win = (win + row[cur][k-1]) % modulus;
        if (k >= n_faces + 1) begin
          win = (win + modulus - row[cur][k-1-n_faces]) % modulus;
        end
        if (n_faces == 0) begin
          win = 0;
        end
        row[nxt][k] = win;
      end
      cur = nxt;
    end
    return WAYS_W'(row[cur][tgt]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    roll_query_t q;
    if (!rst) begin
      if (req_mon.valid && req_mon.ready) begin
        q.dice       = req_mon.dice;
        q.faces      = req_mon.faces;
        q.target_sum = req_mon.target_sum;
        q.ways       = count_rolls(req_mon.dice, req_mon.faces, req_mon.target_sum);
        ways_expected.push_back(q);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (ways_expected.size() == 0) begin
          report_mismatch($sformatf("result word %0d with no query waiting", rsp_mon.ways));
        end else begin
          q = ways_expected.pop_front();
          if (rsp_mon.ways !== q.ways) begin
            report_mismatch($sformatf("dice %0d faces %0d target %0d: ways %0d, wanted %0d",
                                      q.dice, q.faces, q.target_sum, rsp_mon.ways, q.ways));
          end
        end
      end
      pending = ways_expected.size();
    end
  end

endmodule

// ===== test/tb_dice_sum_ways_counter.sv =====
// ----------------------------------------------------------------------------
// Dice sum ways counter testbench
// Drives directed queries at the field extremes and the special cases, then
// random queries, mostly well formed, through four idling phases on the query
// and result channels. One long result stall lets the block fill up and hold
// off further queries. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_dice_sum_ways_counter;
  import dsw_pkg::*;

  typedef enum int {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_IDLE
  } idle_phase_t;

  localparam int ITEMS_PER_PHASE  = 20;
  localparam int PRESSURE_ITEMS   = 10;
  localparam int LONG_HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES     = MAX_TARGET + MAX_DICE + 16;

  logic        clk;
  logic        rst;
  int          fail_count;
  int          pending;
  idle_phase_t phase;
  bit          long_hold;

  dsw_req_if req_ch ();
  dsw_rsp_if rsp_ch ();

  dice_sum_ways_counter DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  dice_sum_ways_check ways_check (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #10000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_query(
    input logic [DICE_W-1:0]   dice,
    input logic [FACES_W-1:0]  faces,
    input logic [TARGET_W-1:0] target_sum
  );
    int gap_pct;
    gap_pct = (phase == PH_SEND_GAPS) ? 63 : (phase == PH_BOTH_IDLE) ? 16 : 0;
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.dice       <= dice;
    req_ch.faces      <= faces;
    req_ch.target_sum <= target_sum;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic send_random(input bit short_target);
    int unsigned dice;
    int unsigned faces;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(99) < 70) begin
      dice  = $urandom_range(MAX_DICE, 1);
      faces = $urandom_range(MAX_FACES, 1);
      lo    = dice;
      hi    = dice * faces;
      if (hi > MAX_TARGET) begin
        hi = MAX_TARGET;
      end
      if (short_target && hi > 40) begin
        hi = 40;
      end
      if (lo > hi) begin
        lo = hi;
      end
      send_query(DICE_W'(dice), FACES_W'(faces), TARGET_W'($urandom_range(hi, lo)));
    end else begin
      dice  = $urandom_range(63);
      faces = $urandom_range(63);
      hi    = short_target ? 40 : MAX_TARGET;
      send_query(DICE_W'(dice), FACES_W'(faces), TARGET_W'($urandom_range(hi)));
    end
  endtask

  initial begin
    int hold_count;
    bit hold_served;
    hold_served = 1'b0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) begin
      @(negedge clk);
    end
    forever begin
      if (long_hold && !hold_served) begin
        hold_served = 1'b1;
        rsp_ch.ready <= 1'b0;
        hold_count = 0;
        while (hold_count < LONG_HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
      end else begin
        case (phase)
          PH_RECV_STALLS: rsp_ch.ready <= ($urandom_range(99) >= 63);
          PH_BOTH_IDLE:   rsp_ch.ready <= ($urandom_range(99) >= 16);
          default:        rsp_ch.ready <= 1'b1;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    rst = 1'b1;
    phase = PH_STEADY;
    long_hold = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.dice = '0;
    req_ch.faces = '0;
    req_ch.target_sum = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero dice, zero faces, saturation of dice and faces, and full targets.
    send_query(6'd0, 6'd6, 10'd0);
    send_query(6'd0, 6'd5, 10'd7);
    send_query(6'd0, 6'd0, 10'd0);
    send_query(6'd0, 6'd63, 10'd1023);
    send_query(6'd1, 6'd0, 10'd0);
    send_query(6'd2, 6'd0, 10'd2);
    send_query(6'd1, 6'd1, 10'd1);
    send_query(6'd1, 6'd6, 10'd3);
    send_query(6'd1, 6'd6, 10'd7);
    send_query(6'd2, 6'd6, 10'd7);
    send_query(6'd3, 6'd63, 10'd50);
    send_query(6'd32, 6'd1, 10'd32);
    send_query(6'd32, 6'd1, 10'd31);
    send_query(6'd63, 6'd1, 10'd32);
    send_query(6'd10, 6'd32, 10'd0);
    send_query(6'd32, 6'd32, 10'd32);
    send_query(6'd30, 6'd6, 10'd100);
    send_query(6'd5, 6'd6, 10'd1023);
    send_query(6'd32, 6'd32, 10'd528);
    send_query(6'd32, 6'd32, 10'd1023);
    send_query(6'd63, 6'd63, 10'd1023);
    send_query(6'd33, 6'd33, 10'd600);

    long_hold = 1'b1;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      send_random(1'b1);
    end
    for (int i = PRESSURE_ITEMS; i < ITEMS_PER_PHASE; i++) begin
      send_random(1'b0);
    end
    phase = PH_SEND_GAPS;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      send_random(1'b0);
    end
    phase = PH_RECV_STALLS;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      send_random(1'b0);
    end
    phase = PH_BOTH_IDLE;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      send_random(1'b0);
    end
    req_ch.valid <= 1'b0;

    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== dice_sum_ways_counter.f =====
rtl/dsw_pkg.sv
rtl/dsw_ifs.sv
rtl/dsw_cell.sv
rtl/dice_sum_ways_counter.sv
test/dice_sum_ways_check.sv
test/tb_dice_sum_ways_counter.sv
